### hw/rtl/fad_pkg.sv
// ----------------------------------------------------------------------------
// fad_pkg
// Shared types and constants for the framed answer deframer: control byte
// codes, result kinds, register indexes and the result word layout.
// ----------------------------------------------------------------------------
package fad_pkg;

  // Link control bytes
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] BYTE_ENQ = 8'h05;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_NAK = 8'h15;

  // Default longest frame in bytes
  localparam int MAX_FRAME_DEF = 256;

  // Configuration register widths and reset values
  localparam int MIN_LEN_W = 9;
  localparam logic [7:0]           PREFIX_RST  = 8'h02;
  localparam logic [7:0]           POSTFIX_RST = 8'h03;
  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = 9'd4;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PREFIX  = 2'd0,
    REG_POSTFIX = 2'd1,
    REG_MIN_LEN = 2'd2
  } reg_idx_t;

  // Result kinds
  typedef enum logic [3:0] {
    KIND_PAYLOAD  = 4'd0,
    KIND_OK       = 4'd1,
    KIND_ACK      = 4'd2,
    KIND_NAK      = 4'd3,
    KIND_SHORT    = 4'd4,
    KIND_PREFIX   = 4'd5,
    KIND_POSTFIX  = 4'd6,
    KIND_CHECKSUM = 4'd7,
    KIND_OVERFLOW = 4'd8
  } kind_t;

  // One result word
  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
    logic       last;
  } result_t;

  // Result queue: two words may enter per byte
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = 2;

endpackage

### hw/rtl/fad_if.sv
// ----------------------------------------------------------------------------
// fad_if
// Valid/ready channels of the deframer: received bytes, result words and
// configuration writes.
// ----------------------------------------------------------------------------

// Received byte channel
interface fad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result word channel
interface fad_out_if
  import fad_pkg::*;
;
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] payload;
  logic       last;

  modport source (output valid, output kind, output payload, output last, input ready);
  modport sink   (input valid, input kind, input payload, input last, output ready);
endinterface

// Configuration write channel
interface fad_cfg_if
  import fad_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [1:0]           index;
  logic [MIN_LEN_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/framed_answer_deframer_unit.sv
// ----------------------------------------------------------------------------
// framed_answer_deframer_unit
// Deframes ACK/ENQ/NAK answers and ETX-terminated frames with an XOR
// checksum, one received byte per cycle while in_ch.ready is high.
//
//   channel   dir  fields                    words per byte
//   in_ch     in   rx_byte                   1
//   out_ch    out  kind, payload, last       0 to 2
//   cfg_ch    in   index, data               register write, always ready
//
// One byte is taken per cycle while in_ch.ready is high; its result words
// enter a four word queue at the accepting edge and are offered on out_ch
// from the next cycle, one word per cycle while out_ch.ready is high.
// in_ch.ready is high while the queue holds two words or fewer, so with a
// stalled consumer it drops once three or more words are waiting.
// A frame end gives up to two words (last payload byte and status), so a long
// run of back-to-back frame ends drains one word per cycle while out_ch.ready.
// Reset (rst_n low, synchronous) empties the queue, goes idle and loads the
// register defaults.
// ----------------------------------------------------------------------------
module framed_answer_deframer_unit
  import fad_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fad_in_if.sink    in_ch,
  fad_out_if.source out_ch,
  fad_cfg_if.sink   cfg_ch
);

  localparam int POS_W = $clog2(MAX_FRAME + 1);
  localparam int LEN_W = ((POS_W > MIN_LEN_W) ? POS_W : MIN_LEN_W) + 1;

  // Configuration registers
  logic [7:0]           prefix_r;
  logic [7:0]           postfix_r;
  logic [MIN_LEN_W-1:0] min_len_r;

  // Frame state
  logic             in_frame_r, in_frame_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic [7:0]       prev2_r, prev2_nxt;
  logic [7:0]       xsum_r, xsum_nxt;

  // Result queue
  result_t           q_mem_r [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr_r;
  logic [OUT_AW-1:0] rd_ptr_r;
  logic [OUT_AW:0]   count_r;

  logic       in_acc;
  logic       out_acc;
  logic [7:0] b;
  result_t    res0, res1;
  logic [1:0] n_res;
  kind_t      status;
  logic [LEN_W-1:0] frame_len;

  assign b       = in_ch.rx_byte;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // Configuration writes; indexes past the list are dropped
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r  <= PREFIX_RST;
      postfix_r <= POSTFIX_RST;
      min_len_r <= MIN_LEN_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_PREFIX:  prefix_r  <= cfg_ch.data[7:0];
        REG_POSTFIX: postfix_r <= cfg_ch.data[7:0];
        REG_MIN_LEN: min_len_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Frame check, first failure wins
  assign frame_len = LEN_W'(pos_r) + LEN_W'(1);

  always_comb begin
    if (frame_len < LEN_W'(min_len_r)) begin
      status = KIND_SHORT;
    end else if (first_r != prefix_r) begin
      status = KIND_PREFIX;
    end else if (prev_r != postfix_r) begin
      status = KIND_POSTFIX;
    end else if (b != xsum_r) begin
      status = KIND_CHECKSUM;
    end else begin
      status = KIND_OK;
    end
  end

  // Per-byte decode: results and next frame state
  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    first_nxt    = first_r;
    prev_nxt     = prev_r;
    prev2_nxt    = prev2_r;
    xsum_nxt     = xsum_r;
    res0         = '{kind: KIND_PAYLOAD, payload: 8'h00, last: 1'b0};
    res1         = '{kind: KIND_PAYLOAD, payload: 8'h00, last: 1'b0};
    n_res        = 2'd0;

    if (!in_frame_r) begin
      if (b == BYTE_ACK || b == BYTE_ENQ) begin
        res0  = '{kind: KIND_ACK, payload: 8'h00, last: 1'b1};
        n_res = 2'd1;
      end else if (b == BYTE_NAK) begin
        res0  = '{kind: KIND_NAK, payload: 8'h00, last: 1'b1};
        n_res = 2'd1;
      end else begin
        // frame opens
        in_frame_nxt = 1'b1;
        first_nxt    = b;
        prev_nxt     = b;
        prev2_nxt    = 8'h00;
        xsum_nxt     = 8'h00;
        pos_nxt      = POS_W'(1);
      end
    end else if (pos_r >= POS_W'(MAX_FRAME)) begin
      // byte would overrun the frame: drop it and go idle
      res0         = '{kind: KIND_OVERFLOW, payload: 8'h00, last: 1'b1};
      n_res        = 2'd1;
      in_frame_nxt = 1'b0;
      pos_nxt      = '0;
      first_nxt    = 8'h00;
      prev_nxt     = 8'h00;
      prev2_nxt    = 8'h00;
      xsum_nxt     = 8'h00;
    end else begin
      // byte two back is payload once past the first byte
      if (pos_r >= POS_W'(3)) begin
        res0  = '{kind: KIND_PAYLOAD, payload: prev2_r, last: 1'b0};
        n_res = 2'd1;
      end
      if (prev_r == BYTE_ETX) begin
        // checksum byte: status closes the frame
        if (n_res == 2'd1) begin
          res1  = '{kind: status, payload: 8'h00, last: 1'b1};
          n_res = 2'd2;
        end else begin
          res0  = '{kind: status, payload: 8'h00, last: 1'b1};
          n_res = 2'd1;
        end
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
        first_nxt    = 8'h00;
        prev_nxt     = 8'h00;
        prev2_nxt    = 8'h00;
        xsum_nxt     = 8'h00;
      end else begin
        xsum_nxt  = xsum_r ^ b;
        prev2_nxt = prev_r;
        prev_nxt  = b;
        pos_nxt   = pos_r + POS_W'(1);
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      first_r    <= 8'h00;
      prev_r     <= 8'h00;
      prev2_r    <= 8'h00;
      xsum_r     <= 8'h00;
    end else if (in_acc) begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      first_r    <= first_nxt;
      prev_r     <= prev_nxt;
      prev2_r    <= prev2_nxt;
      xsum_r     <= xsum_nxt;
    end
  end

  // Result queue: up to two pushes and one pop per cycle
  logic [1:0]      n_push;
  logic [OUT_AW:0] count_nxt;

  assign n_push    = in_acc ? n_res : 2'd0;
  assign count_nxt = count_r + (OUT_AW+1)'(n_push) - (OUT_AW+1)'(out_acc);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_mem_r[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      q_mem_r[wr_ptr_r + OUT_AW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OUT_AW'(n_push);
      rd_ptr_r <= rd_ptr_r + OUT_AW'(out_acc);
      count_r  <= count_nxt;
    end
  end

  assign in_ch.ready    = (count_r <= (OUT_AW+1)'(OUT_DEPTH - 2));
  assign out_ch.valid   = (count_r != '0);
  assign out_ch.kind    = q_mem_r[rd_ptr_r].kind;
  assign out_ch.payload = q_mem_r[rd_ptr_r].payload;
  assign out_ch.last    = q_mem_r[rd_ptr_r].last;

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (OUT_AW+1)'(OUT_DEPTH))
    else $error("result queue overfilled");

  a_pos_tracks_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r == (pos_r != '0))
    else $error("frame position out of step with frame flag");

  a_open_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_frame_r && b != BYTE_ACK && b != BYTE_ENQ && b != BYTE_NAK)
    |=> in_frame_r)
    else $error("opening byte did not start a frame");

  a_overflow_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_frame_r && pos_r >= POS_W'(MAX_FRAME)) |=> !in_frame_r)
    else $error("overflow did not return to idle");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last == (out_ch.kind != KIND_PAYLOAD)))
    else $error("last flag disagrees with kind");

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the framed answer deframer. Bytes go in through
// the valid/ready byte channel with random gaps, result words are drained
// with random stalls, and every word is compared against a deframing
// predictor kept in step with each accepted byte. A short directed table
// comes first (control answers, good and broken frames at reset settings),
// then random phases that each load a register setting.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fad_pkg::*;

  localparam int         FRAME_LIMIT   = MAX_FRAME_DEF;
  localparam int         PHASE_BYTES   = 30;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         TAIL_CYCLES   = 40;
  localparam logic [1:0] REG_UNUSED    = 2'd3;

  // One row of the directed table; status is checked only when has_status
  typedef struct packed {
    logic [7:0] rx;
    logic       has_status;
    kind_t      status;
  } dir_row_t;

  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    // single-byte answers
    '{BYTE_ACK, 1'b1, KIND_ACK},
    '{BYTE_ENQ, 1'b1, KIND_ACK},
    '{BYTE_NAK, 1'b1, KIND_NAK},
    // good frame, checksum 0x41 ^ 0x03
    '{PREFIX_RST, 1'b0, KIND_PAYLOAD},
    '{8'h41,      1'b0, KIND_PAYLOAD},
    '{BYTE_ETX,   1'b0, KIND_PAYLOAD},
    '{8'h42,      1'b1, KIND_OK},
    // same frame, wrong checksum
    '{PREFIX_RST, 1'b0, KIND_PAYLOAD},
    '{8'h41,      1'b0, KIND_PAYLOAD},
    '{BYTE_ETX,   1'b0, KIND_PAYLOAD},
    '{8'h00,      1'b1, KIND_CHECKSUM},
    // ETX as first byte: two-byte frame, too short
    '{BYTE_ETX,   1'b0, KIND_PAYLOAD},
    '{8'h00,      1'b1, KIND_SHORT},
    // extreme bytes, wrong lead byte
    '{8'hFF,      1'b0, KIND_PAYLOAD},
    '{8'h00,      1'b0, KIND_PAYLOAD},
    '{BYTE_ETX,   1'b0, KIND_PAYLOAD},
    '{BYTE_ETX,   1'b1, KIND_PREFIX},
    // control bytes inside a frame are plain data
    '{PREFIX_RST, 1'b0, KIND_PAYLOAD},
    '{BYTE_ACK,   1'b0, KIND_PAYLOAD},
    '{BYTE_NAK,   1'b0, KIND_PAYLOAD},
    '{BYTE_ENQ,   1'b0, KIND_PAYLOAD},
    '{BYTE_ETX,   1'b0, KIND_PAYLOAD},
    '{8'h15,      1'b1, KIND_OK}
  };

  logic clk;
  logic rst_n;

  fad_in_if  in_ch ();
  fad_out_if out_ch ();
  fad_cfg_if cfg_ch ();

  framed_answer_deframer_unit #(
    .MAX_FRAME (FRAME_LIMIT)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Register mirror
  logic [7:0]           prefix_reg;
  logic [7:0]           postfix_reg;
  logic [MIN_LEN_W-1:0] min_len_reg;

  // Deframer state mirror
  bit         frame_open;
  int         frame_pos;
  logic [7:0] lead_byte;
  logic [7:0] last_byte;
  logic [7:0] older_byte;
  logic [7:0] running_xor;
  kind_t      last_status;

  result_t expected_words [$];

  int  mismatches;
  int  bytes_sent;
  int  words_seen;
  int  settings_loaded;
  int  kind_seen [0:8];
  bit  no_gaps;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop
  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic void emit_status(input kind_t k);
    expected_words.push_back('{k, 8'h00, 1'b1});
    last_status = k;
  endfunction

  // Expected words for one accepted byte
  function automatic void deframe_byte(input logic [7:0] b);
    int    length;
    kind_t verdict;
    if (!frame_open) begin
      if (b == BYTE_ACK || b == BYTE_ENQ) begin
        emit_status(KIND_ACK);
        return;
      end
      if (b == BYTE_NAK) begin
        emit_status(KIND_NAK);
        return;
      end
      frame_open  = 1'b1;
      lead_byte   = b;
      last_byte   = b;
      older_byte  = 8'h00;
      running_xor = 8'h00;
      frame_pos   = 1;
      return;
    end
    // byte would exceed the frame limit: dropped, overflow only
    if (frame_pos >= FRAME_LIMIT) begin
      frame_open = 1'b0;
      emit_status(KIND_OVERFLOW);
      return;
    end
    // payload trails the input by two bytes
    if (frame_pos >= 3)
      expected_words.push_back('{KIND_PAYLOAD, older_byte, 1'b0});
    // byte after ETX is the checksum
    if (last_byte == BYTE_ETX) begin
      length = frame_pos + 1;
      if (length < min_len_reg)            verdict = KIND_SHORT;
      else if (lead_byte != prefix_reg)    verdict = KIND_PREFIX;
      else if (last_byte != postfix_reg)   verdict = KIND_POSTFIX;
      else if (b != running_xor)           verdict = KIND_CHECKSUM;
      else                                 verdict = KIND_OK;
      emit_status(verdict);
      frame_open = 1'b0;
      return;
    end
    running_xor ^= b;
    older_byte   = last_byte;
    last_byte    = b;
    frame_pos++;
  endfunction

  // Send one byte on the byte channel; called at a falling edge
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.rx_byte = b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    deframe_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Register write; valid is left high for back-to-back writes
  task automatic write_reg(input logic [1:0] idx, input logic [MIN_LEN_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      REG_PREFIX:  prefix_reg  = value[7:0];
      REG_POSTFIX: postfix_reg = value[7:0];
      REG_MIN_LEN: min_len_reg = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Frame: lead byte, body without ETX, ETX, checksum
  task automatic send_frame(input int body_len, input bit bad_lead, input bit bad_sum);
    logic [7:0] b;
    logic [7:0] sum;
    no_gaps = ($urandom_range(0, 5) == 0);
    b = bad_lead ? 8'($urandom_range(0, 255)) : prefix_reg;
    push_byte(b);
    sum = 8'h00;
    for (int i = 0; i < body_len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == BYTE_ETX) b = b ^ 8'h01;
      push_byte(b);
      sum ^= b;
    end
    push_byte(BYTE_ETX);
    sum ^= BYTE_ETX;
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    push_byte(sum);
  endtask

  // Close any open frame, then wait for the block to go quiet
  task automatic settle();
    while (frame_open) push_byte(BYTE_ETX);
    in_ch.valid = 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_prefix();
    logic [7:0] p;
    do p = 8'($urandom_range(0, 255));
    while (p == BYTE_ACK || p == BYTE_ENQ || p == BYTE_NAK);
    return p;
  endfunction

  // Result sink: random stall per word, compare against the oldest expectation
  initial begin
    int      stall;
    result_t want;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      words_seen++;
      if (out_ch.kind <= KIND_OVERFLOW) kind_seen[out_ch.kind]++;
      if (expected_words.size() == 0) begin
        $error("unexpected word: kind %0d payload 0x%02h last %0b",
               out_ch.kind, out_ch.payload, out_ch.last);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          mismatches++;
        end
        if (out_ch.payload !== want.payload) begin
          $error("payload: expected 0x%02h, got 0x%02h", want.payload, out_ch.payload);
          mismatches++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_ch.last);
          mismatches++;
        end
      end
      @(negedge clk);
    end
  end

  // Main sequence
  initial begin
    logic [7:0]           pre;
    logic [7:0]           post;
    logic [MIN_LEN_W-1:0] minl;
    logic [MIN_LEN_W-1:0] cfg_val;
    int                   phase_start;
    int                   pick;

    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_PREFIX;
    cfg_ch.data   = '0;
    rst_n         = 1'b0;
    mismatches    = 0;
    bytes_sent    = 0;
    words_seen    = 0;
    settings_loaded = 0;
    no_gaps       = 1'b0;
    frame_open    = 1'b0;
    frame_pos     = 0;
    lead_byte     = 8'h00;
    last_byte     = 8'h00;
    older_byte    = 8'h00;
    running_xor   = 8'h00;
    last_status   = KIND_PAYLOAD;
    prefix_reg    = PREFIX_RST;
    postfix_reg   = POSTFIX_RST;
    min_len_reg   = MIN_LEN_RST;
    foreach (kind_seen[k]) kind_seen[k] = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table at reset settings
    for (int r = 0; r < DIR_ROWS; r++) begin
      last_status = KIND_PAYLOAD;
      push_byte(DIRECTED_ROWS[r].rx);
      if (DIRECTED_ROWS[r].has_status && last_status != DIRECTED_ROWS[r].status) begin
        $error("row %0d status: expected %0d, got %0d",
               r, DIRECTED_ROWS[r].status, last_status);
        mismatches++;
      end
    end

    // Random phases, one register setting each
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin pre = PREFIX_RST;    post = POSTFIX_RST;   minl = MIN_LEN_RST; end
        1: begin pre = 8'h00;         post = 8'h00;         minl = 9'd3;        end
        2: begin pre = 8'hFF;         post = 8'hFF;         minl = 9'd256;      end
        3: begin pre = PREFIX_RST;    post = BYTE_ETX;      minl = 9'd0;        end
        4: begin pre = pick_prefix(); post = BYTE_ETX;      minl = 9'd511;      end
        5: begin pre = PREFIX_RST;    post = BYTE_ETX;      minl = 9'd1;        end
        6: begin
          pre  = pick_prefix();
          post = 8'($urandom_range(0, 255));
          minl = 9'($urandom_range(0, 12));
        end
        default: begin pre = pick_prefix(); post = BYTE_ETX; minl = 9'd2; end
      endcase
      settle();
      // bit 8 of an 8-bit register write is don't-care
      cfg_val = 9'($urandom_range(0, 511));
      cfg_val[7:0] = pre;
      write_reg(REG_PREFIX, cfg_val);
      cfg_val = 9'($urandom_range(0, 511));
      cfg_val[7:0] = post;
      write_reg(REG_POSTFIX, cfg_val);
      write_reg(REG_MIN_LEN, minl);
      if (phase == 6) write_reg(REG_UNUSED, 9'($urandom_range(0, 511)));
      cfg_ch.valid = 1'b0;
      settings_loaded++;

      // longest legal frame and one byte past it
      if (phase == 0) begin
        send_frame(FRAME_LIMIT - 3, 1'b0, 1'b0);
        send_frame(FRAME_LIMIT - 2, 1'b0, 1'b0);
      end

      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        pick = $urandom_range(0, 7);
        case (pick)
          0: push_byte(8'($urandom_range(0, 255)));
          1: send_frame($urandom_range(0, 8), 1'b1, 1'b0);
          2: send_frame($urandom_range(0, 8), 1'b0, 1'b1);
          default: send_frame($urandom_range(0, 8), 1'b0, 1'b0);
        endcase
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Run: %0d bytes in, %0d words checked, %0d register settings",
             bytes_sent, words_seen, settings_loaded + 1);
    $display("Statuses: ok %0d ack/enq %0d nak %0d short %0d prefix %0d postfix %0d",
             kind_seen[KIND_OK], kind_seen[KIND_ACK], kind_seen[KIND_NAK],
             kind_seen[KIND_SHORT], kind_seen[KIND_PREFIX], kind_seen[KIND_POSTFIX]);
    $display("          checksum %0d overflow %0d payload %0d",
             kind_seen[KIND_CHECKSUM], kind_seen[KIND_OVERFLOW], kind_seen[KIND_PAYLOAD]);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
